### src/cdq_pkg.sv
// ============================================================================
// cdq_pkg
// Shared types, constants and index helpers for the circular deque.
// ============================================================================
package cdq_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int WORD_W      = 32;
    localparam int KIND_W      = 3;
    localparam int STAT_W      = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_REAR  = 3'd1,
        K_POP_FRONT  = 3'd2,
        K_POP_REAR   = 3'd3,
        K_PEEK_FRONT = 3'd4,
        K_PEEK_REAR  = 3'd5
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // capacity clamped to 1..MAX_ENTRIES
    function automatic logic [CNT_W-1:0] used_entries(input logic [CAP_W-1:0] cap);
        logic [CNT_W-1:0] res;
        if (cap == '0) begin
            res = CNT_W'(1);
        end else if (int'(cap) > MAX_ENTRIES) begin
            res = CNT_W'(MAX_ENTRIES);
        end else begin
            res = CNT_W'(cap);
        end
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] n);
        logic [IDX_W:0] nxt;
        logic [IDX_W:0] lim;
        nxt = {1'b0, idx} + (IDX_W+1)'(1);
        lim = (IDX_W+1)'(n);
        return (nxt >= lim) ? '0 : nxt[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx,
                                                   input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] top;
        top = n - CNT_W'(1);
        return (idx == '0) ? IDX_W'(top) : idx - IDX_W'(1);
    endfunction

endpackage

### src/circular_deque.sv
// ============================================================================
// circular_deque
// Double-ended queue of 32-bit words in a synchronous ring memory.
// ============================================================================
// One request word per cycle is taken while the output side keeps up; the
// input stalls only when both the read stage and the output register hold
// unconsumed results. The indexes and the empty flag are updated at
// acceptance, the ring memory is written or read in the same cycle, and the
// result passes the memory read stage and an output register. The user must
// write capacity only while the deque is idle; the block does not enforce it.
module circular_deque (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wen,
    input  logic [cdq_pkg::CAP_W-1:0]   i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [cdq_pkg::WORD_W-1:0]  s_axis_tdata,  // [31:0] value
    input  logic [cdq_pkg::KIND_W-1:0]  s_axis_tuser,  // [2:0] kind
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [cdq_pkg::WORD_W-1:0]  m_axis_tdata,  // [31:0] data
    output logic [cdq_pkg::STAT_W-1:0]  m_axis_tuser   // [1:0] status
);

    logic [cdq_pkg::WORD_W-1:0] r_mem [cdq_pkg::MAX_ENTRIES];
    logic [cdq_pkg::WORD_W-1:0] r_rd_data;

    logic [cdq_pkg::CNT_W-1:0]  r_used;
    logic [cdq_pkg::IDX_W-1:0]  r_head, n_head;
    logic [cdq_pkg::IDX_W-1:0]  r_tail, n_tail;
    logic                       r_empty, n_empty;

    logic                       r_s2_valid;
    logic                       r_s2_rd, n_s2_rd;
    cdq_pkg::t_status           r_s2_status, n_s2_status;

    logic                       r_out_valid;
    logic [cdq_pkg::WORD_W-1:0] r_out_data;
    cdq_pkg::t_status           r_out_status;

    logic                       s2_move;
    logic                       accept;
    logic                       full;
    logic                       wr_en, rd_en;
    logic [cdq_pkg::IDX_W-1:0]  wr_addr, rd_addr;
    cdq_pkg::t_kind             kind;

    assign kind          = cdq_pkg::t_kind'(s_axis_tuser);
    assign s2_move       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s2_valid || s2_move;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full          = !r_empty && (cdq_pkg::step_up(r_tail, r_used) == r_head);

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_empty     = r_empty;
        n_s2_rd     = 1'b0;
        n_s2_status = cdq_pkg::ST_DONE;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = '0;
        rd_addr     = r_tail;
        case (kind) inside
            cdq_pkg::K_PUSH_FRONT, cdq_pkg::K_PUSH_REAR: begin
                if (full) begin
                    n_s2_status = cdq_pkg::ST_FULL;
                end else if (r_empty) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b0;
                    wr_en   = 1'b1;
                end else if (kind == cdq_pkg::K_PUSH_FRONT) begin
                    n_head  = cdq_pkg::step_down(r_head, r_used);
                    wr_addr = n_head;
                    wr_en   = 1'b1;
                end else begin
                    n_tail  = cdq_pkg::step_up(r_tail, r_used);
                    wr_addr = n_tail;
                    wr_en   = 1'b1;
                end
            end
            cdq_pkg::K_POP_FRONT, cdq_pkg::K_POP_REAR: begin
                if (r_empty) begin
                    n_s2_status = cdq_pkg::ST_EMPTY;
                end else if (r_head == r_tail) begin
                    rd_en   = 1'b1;
                    n_s2_rd = 1'b1;
                    n_head  = '0;
                    n_tail  = '0;
                    n_empty = 1'b1;
                end else if (kind == cdq_pkg::K_POP_FRONT) begin
                    rd_en   = 1'b1;
                    n_s2_rd = 1'b1;
                    rd_addr = r_head;
                    n_head  = cdq_pkg::step_up(r_head, r_used);
                end else begin
                    rd_en   = 1'b1;
                    n_s2_rd = 1'b1;
                    n_tail  = cdq_pkg::step_down(r_tail, r_used);
                end
            end
            cdq_pkg::K_PEEK_FRONT, cdq_pkg::K_PEEK_REAR: begin
                if (r_empty) begin
                    n_s2_status = cdq_pkg::ST_EMPTY;
                end else begin
                    rd_en   = 1'b1;
                    n_s2_rd = 1'b1;
                    rd_addr = (kind == cdq_pkg::K_PEEK_FRONT) ? r_head : r_tail;
                end
            end
            default: begin
            end
        endcase
    end

    // ring memory
    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_mem[wr_addr] <= s_axis_tdata;
        end
        if (accept && rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= cdq_pkg::used_entries(cdq_pkg::CAP_RESET);
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_s2_valid  <= 1'b0;
            r_s2_rd     <= 1'b0;
            r_s2_status <= cdq_pkg::ST_DONE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_used <= cdq_pkg::used_entries(i_cfg_wdata);
            end
            if (accept) begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_empty     <= n_empty;
                r_s2_rd     <= n_s2_rd;
                r_s2_status <= n_s2_status;
            end
            if (s_axis_tready) begin
                r_s2_valid <= accept;
            end
            if (s2_move) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move && r_s2_valid) begin
            r_out_data   <= r_s2_rd ? r_rd_data : '0;
            r_out_status <= r_s2_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

endmodule

### src/cdq_checker.sv
// ============================================================================
// cdq_checker
// Port-level checks for the circular deque, bound to the top level.
// ============================================================================
module cdq_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tready,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [cdq_pkg::WORD_W-1:0]  m_axis_tdata,
    input  logic [cdq_pkg::STAT_W-1:0]  m_axis_tuser
);

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == cdq_pkg::ST_DONE ||
                           m_axis_tuser == cdq_pkg::ST_FULL ||
                           m_axis_tuser == cdq_pkg::ST_EMPTY))
        else $error("undefined status code");

    // refused requests return a zero word
    a_refusal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != cdq_pkg::ST_DONE) |-> (m_axis_tdata == '0))
        else $error("refusal with nonzero data");

    // input back-pressure only while the output is stalled
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output back-pressure");

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/sv/cdq_result_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// cdq_result_checker
// Keeps its own copy of the deque contents, indexes and capacity. It predicts
// the response to every accepted request and compares each accepted response,
// in order, against the oldest prediction that has not been matched yet.
// ============================================================================
module cdq_result_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wen,
    input  logic [cdq_pkg::CAP_W-1:0]   i_cfg_wdata,
    input  logic                        i_req_valid,
    input  logic                        i_req_ready,
    input  logic [cdq_pkg::WORD_W-1:0]  i_req_value,
    input  logic [cdq_pkg::KIND_W-1:0]  i_req_kind,
    input  logic                        i_rsp_valid,
    input  logic                        i_rsp_ready,
    input  logic [cdq_pkg::WORD_W-1:0]  i_rsp_data,
    input  logic [cdq_pkg::STAT_W-1:0]  i_rsp_status,
    output int                          o_pending,
    output int                          o_fail_count,
    output int                          o_checked,
    output int                          o_full_refusals,
    output int                          o_empty_refusals
);

    typedef struct packed {
        logic [cdq_pkg::WORD_W-1:0] data;
        cdq_pkg::t_status           status;
    } t_deque_rsp;

    t_deque_rsp                 rsp_expected_q[$];
    logic [cdq_pkg::WORD_W-1:0] ring_copy [cdq_pkg::MAX_ENTRIES];
    bit                         ring_written [cdq_pkg::MAX_ENTRIES];
    logic [cdq_pkg::IDX_W-1:0]  front_idx;
    logic [cdq_pkg::IDX_W-1:0]  rear_idx;
    bit                         deque_empty;
    logic [cdq_pkg::CAP_W-1:0]  capacity;

    function automatic int ring_entries();
        if (capacity == '0) return 1;
        if (int'(capacity) > cdq_pkg::MAX_ENTRIES) return cdq_pkg::MAX_ENTRIES;
        return int'(capacity);
    endfunction

    function automatic logic [cdq_pkg::IDX_W-1:0] ring_next(
        input logic [cdq_pkg::IDX_W-1:0] idx);
        return (int'(idx) + 1 >= ring_entries()) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [cdq_pkg::IDX_W-1:0] ring_prev(
        input logic [cdq_pkg::IDX_W-1:0] idx);
        return (idx == '0) ? cdq_pkg::IDX_W'(ring_entries() - 1) : idx - 1'b1;
    endfunction

    function automatic logic [cdq_pkg::WORD_W-1:0] ring_read(
        input logic [cdq_pkg::IDX_W-1:0] idx);
        return ring_written[idx] ? ring_copy[idx] : '0;
    endfunction

    function automatic void ring_write(input logic [cdq_pkg::IDX_W-1:0]  idx,
                                       input logic [cdq_pkg::WORD_W-1:0] value);
        ring_copy[idx]    = value;
        ring_written[idx] = 1'b1;
    endfunction

    function automatic t_deque_rsp apply_request(input logic [cdq_pkg::KIND_W-1:0] kind,
                                                 input logic [cdq_pkg::WORD_W-1:0] value);
        t_deque_rsp rsp;
        bit         is_full;
        rsp.data   = '0;
        rsp.status = cdq_pkg::ST_DONE;
        is_full    = !deque_empty && (ring_next(rear_idx) == front_idx);
        case (kind)
            cdq_pkg::K_PUSH_FRONT, cdq_pkg::K_PUSH_REAR: begin
                if (is_full) begin
                    rsp.status = cdq_pkg::ST_FULL;
                end else if (deque_empty) begin
                    front_idx   = '0;
                    rear_idx    = '0;
                    deque_empty = 1'b0;
                    ring_write('0, value);
                end else if (kind == cdq_pkg::K_PUSH_FRONT) begin
                    front_idx = ring_prev(front_idx);
                    ring_write(front_idx, value);
                end else begin
                    rear_idx = ring_next(rear_idx);
                    ring_write(rear_idx, value);
                end
            end
            cdq_pkg::K_POP_FRONT, cdq_pkg::K_POP_REAR: begin
                if (deque_empty) begin
                    rsp.status = cdq_pkg::ST_EMPTY;
                end else if (front_idx == rear_idx) begin
                    rsp.data    = ring_read(rear_idx);
                    front_idx   = '0;
                    rear_idx    = '0;
                    deque_empty = 1'b1;
                end else if (kind == cdq_pkg::K_POP_FRONT) begin
                    rsp.data  = ring_read(front_idx);
                    front_idx = ring_next(front_idx);
                end else begin
                    rsp.data = ring_read(rear_idx);
                    rear_idx = ring_prev(rear_idx);
                end
            end
            cdq_pkg::K_PEEK_FRONT, cdq_pkg::K_PEEK_REAR: begin
                if (deque_empty) begin
                    rsp.status = cdq_pkg::ST_EMPTY;
                end else begin
                    rsp.data = ring_read((kind == cdq_pkg::K_PEEK_FRONT) ?
                                         front_idx : rear_idx);
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    always @(posedge i_clk) begin : watch
        t_deque_rsp want;
        if (!i_rst_n) begin
            capacity    = cdq_pkg::CAP_RESET;
            front_idx   = '0;
            rear_idx    = '0;
            deque_empty = 1'b1;
            foreach (ring_written[i]) ring_written[i] = 1'b0;
            rsp_expected_q.delete();
        end else begin
            if (i_cfg_wen) begin
                capacity = i_cfg_wdata;
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (rsp_expected_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got data %h status %0d",
                             $time, i_rsp_data, i_rsp_status);
                    o_fail_count++;
                end else begin
                    want = rsp_expected_q.pop_front();
                    o_checked++;
                    if (want.status == cdq_pkg::ST_FULL) o_full_refusals++;
                    if (want.status == cdq_pkg::ST_EMPTY) o_empty_refusals++;
                    if (i_rsp_data !== want.data) begin
                        $display("%0t: data mismatch, expected %h, got %h",
                                 $time, want.data, i_rsp_data);
                        o_fail_count++;
                    end
                    if (i_rsp_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, i_rsp_status);
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                rsp_expected_q.push_back(apply_request(i_req_kind, i_req_value));
            end
        end
        o_pending <= rsp_expected_q.size();
    end

endmodule

### tb/sv/tb_circular_deque.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_circular_deque
// Drives push, pop and peek requests into the circular deque with random
// gaps and output stalls, across a series of capacity settings including
// the clamped and extreme ones. A separate checker predicts every response.
// ============================================================================
module tb_circular_deque;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 4;
    localparam int GAP_MAX        = 14;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 56;

    localparam logic [cdq_pkg::KIND_W-1:0] K_SPARE_LO = 3'd6;
    localparam logic [cdq_pkg::KIND_W-1:0] K_SPARE_HI = 3'd7;

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        cfg_wen       = 1'b0;
    logic [cdq_pkg::CAP_W-1:0]   cfg_wdata     = '0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [cdq_pkg::WORD_W-1:0]  s_axis_tdata  = '0;
    logic [cdq_pkg::KIND_W-1:0]  s_axis_tuser  = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [cdq_pkg::WORD_W-1:0]  m_axis_tdata;
    logic [cdq_pkg::STAT_W-1:0]  m_axis_tuser;

    bit  steady_flow    = 1'b0;
    int  sent_count     = 0;
    int  capacity_count = 1;
    int  stalled_cycles = 0;
    int  pending;
    int  fail_count;
    int  checked;
    int  full_refusals;
    int  empty_refusals;

    logic [cdq_pkg::CAP_W-1:0] cap_plan [RANDOM_PHASES] =
        '{5'd0, 5'd31, 5'd17, 5'd2, 5'd3, 5'd16, 5'd7, 5'd1, 5'd12, 5'd5};
    bit keep_plan [RANDOM_PHASES] =
        '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    circular_deque dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wen     (cfg_wen),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),  // [31:0] value
        .s_axis_tuser  (s_axis_tuser),  // [2:0] kind
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),  // [31:0] data
        .m_axis_tuser  (m_axis_tuser)   // [1:0] status
    );

    cdq_result_checker u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wen        (cfg_wen),
        .i_cfg_wdata      (cfg_wdata),
        .i_req_valid      (s_axis_tvalid),
        .i_req_ready      (s_axis_tready),
        .i_req_value      (s_axis_tdata),
        .i_req_kind       (s_axis_tuser),
        .i_rsp_valid      (m_axis_tvalid),
        .i_rsp_ready      (m_axis_tready),
        .i_rsp_data       (m_axis_tdata),
        .i_rsp_status     (m_axis_tuser),
        .o_pending        (pending),
        .o_fail_count     (fail_count),
        .o_checked        (checked),
        .o_full_refusals  (full_refusals),
        .o_empty_refusals (empty_refusals)
    );

    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, stalled_cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : result_sink
        int stall;
        do @(posedge clk); while (!rst_n);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_word(input logic [cdq_pkg::KIND_W-1:0] kind,
                             input logic [cdq_pkg::WORD_W-1:0] value);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= value;
        do @(posedge clk); while (!s_axis_tready);
        sent_count++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [cdq_pkg::CAP_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        capacity_count++;
    endtask

    function automatic logic [cdq_pkg::KIND_W-1:0] pick_kind(input int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            return $urandom_range(0, 1) ? cdq_pkg::K_PEEK_FRONT : cdq_pkg::K_PEEK_REAR;
        end
        if (roll < 12 + push_pct) begin
            return $urandom_range(0, 1) ? cdq_pkg::K_PUSH_FRONT : cdq_pkg::K_PUSH_REAR;
        end
        return $urandom_range(0, 1) ? cdq_pkg::K_POP_FRONT : cdq_pkg::K_POP_REAR;
    endfunction

    function automatic logic [cdq_pkg::WORD_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        int push_pct;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty deque at reset capacity
        send_word(cdq_pkg::K_PEEK_FRONT, '1);
        send_word(cdq_pkg::K_PEEK_REAR, '1);
        send_word(cdq_pkg::K_POP_FRONT, '1);
        send_word(cdq_pkg::K_POP_REAR, '1);
        send_word(cdq_pkg::K_PUSH_FRONT, 32'h8000_0000);
        send_word(cdq_pkg::K_PUSH_REAR, 32'h7FFF_FFFF);
        send_word(cdq_pkg::K_PUSH_FRONT, 32'hFFFF_FFFF);
        send_word(cdq_pkg::K_PUSH_REAR, 32'h0000_0000);
        send_word(cdq_pkg::K_PEEK_FRONT, 32'h1234_5678);
        send_word(cdq_pkg::K_PEEK_REAR, 32'h1234_5678);
        send_word(K_SPARE_LO, 32'hDEAD_BEEF);
        send_word(K_SPARE_HI, 32'hFFFF_FFFF);
        send_word(cdq_pkg::K_POP_REAR, '0);
        send_word(cdq_pkg::K_POP_FRONT, '0);
        send_word(cdq_pkg::K_POP_FRONT, '0);
        send_word(cdq_pkg::K_POP_REAR, '0);
        send_word(cdq_pkg::K_POP_FRONT, '0);
        wait_idle();

        // single entry ring
        set_capacity(cdq_pkg::CAP_W'(1));
        send_word(cdq_pkg::K_PUSH_REAR, 32'hA5A5_A5A5);
        send_word(cdq_pkg::K_PUSH_FRONT, 32'h5A5A_5A5A);
        send_word(cdq_pkg::K_PEEK_REAR, '0);
        send_word(cdq_pkg::K_POP_FRONT, '0);
        send_word(cdq_pkg::K_PUSH_FRONT, 32'h5A5A_5A5A);
        send_word(cdq_pkg::K_POP_REAR, '0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            steady_flow = (phase % 3 == 2);
            repeat (cdq_pkg::MAX_ENTRIES) begin
                send_word($urandom_range(0, 1) ? cdq_pkg::K_POP_FRONT : cdq_pkg::K_POP_REAR,
                          '0);
            end
            // a short unwrapped fill survives the capacity change
            if (keep_plan[phase]) begin
                repeat ($urandom_range(1, 4)) send_word(cdq_pkg::K_PUSH_REAR, pick_value());
            end
            wait_idle();
            set_capacity(cap_plan[phase]);
            push_pct = 66;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 11) == 0) push_pct = 88 - push_pct;
                send_word(pick_kind(push_pct), pick_value());
            end
        end

        wait_idle();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        $display("run covered %0d requests over %0d capacity settings, %0d results checked",
                 sent_count, capacity_count, checked);
        $display("refused pushes on a full deque: %0d, refused reads on an empty one: %0d",
                 full_refusals, empty_refusals);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
src/cdq_pkg.sv
src/circular_deque.sv
src/cdq_checker.sv
tb/sv/cdq_result_checker.sv
tb/sv/tb_circular_deque.sv
